// File: rtl/core/helix_position_generator_assert.svh
`ifndef HELIX_POSITION_GENERATOR_ASSERT_SVH
`define HELIX_POSITION_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define HPG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define HPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hpg_pkg.sv
package hpg_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int AMPLITUDE_BITS_DEF = 16;

    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Z_START      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_STEP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX   = 3'd5;

    // CORDIC gain compensation, K * 2^30
    localparam int CORDIC_K_Q30 = 652032874;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_INIT = 7'b0000010,
        ST_ROT  = 7'b0000100,
        ST_QUAD = 7'b0001000,
        ST_MULX = 7'b0010000,
        ST_MULY = 7'b0100000,
        ST_EMIT = 7'b1000000
    } hpg_state_t;

    // atan(2^-i), full turn = 2^32
    function automatic logic signed [31:0] atan_angle(input logic [ITER_W-1:0] i);
        logic signed [31:0] a;
        unique case (i)
            4'd0:    a = 32'sd536870912;
            4'd1:    a = 32'sd316933406;
            4'd2:    a = 32'sd167458907;
            4'd3:    a = 32'sd85004756;
            4'd4:    a = 32'sd42667331;
            4'd5:    a = 32'sd21354465;
            4'd6:    a = 32'sd10679838;
            4'd7:    a = 32'sd5340245;
            4'd8:    a = 32'sd2670163;
            4'd9:    a = 32'sd1335087;
            4'd10:   a = 32'sd667544;
            4'd11:   a = 32'sd333772;
            4'd12:   a = 32'sd166886;
            4'd13:   a = 32'sd83443;
            4'd14:   a = 32'sd41722;
            4'd15:   a = 32'sd20861;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/core/helix_position_generator.sv
// Helical path sample generator.
// Input channel (in_valid/in_ready, field restart): each transfer is one tick.
// restart = 1 starts the path at sample 0 (phase_offset, z_start); restart = 0
// advances index, phase and z by one step and gives the next sample. A tick
// after the sample flagged is_last gives no result until the next restart.
// Output channel (out_valid/out_ready): sample_index, pos_x, pos_y, pos_z,
// is_last. x and y come from one CORDIC stage reused for 16 rotation steps,
// then one multiplier reused for the x and y radius scaling.
// Steps per tick: setup, the 16 rotations, quadrant fold, the x and y
// multiplies, then the load into the output register. The shared CORDIC
// stage takes no new tick until the current one reaches the output
// register; in_ready is high only while the sequencer is idle.
// The output register holds a finished sample while the receiver stalls;
// the next tick is still taken, and its sample waits in the load step until
// the output register frees up. Configuration writes (cfg_write, cfg_index,
// cfg_data) take effect at once and belong in idle periods only.
// Reset clears all configuration registers and accumulators and leaves the
// block waiting for a restart.
module helix_position_generator
    import hpg_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int AMPLITUDE_BITS = AMPLITUDE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 restart,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          sample_index,
    output logic signed [16:0]   pos_x,
    output logic signed [16:0]   pos_y,
    output logic signed [31:0]   pos_z,
    output logic                 is_last
);

    // CORDIC datapath width: amplitude plus guard and sign bits
    localparam int XW     = AMPLITUDE_BITS + 3;
    // radius (17 bit signed) times CORDIC output
    localparam int PW     = XW + 17;
    localparam int PH_DOWN = (PHASE_BITS >= 32) ? (PHASE_BITS - 32) : 0;
    localparam int PH_UP   = (PHASE_BITS < 32) ? (32 - PHASE_BITS) : 0;
    localparam int X_INIT_I = (CORDIC_K_Q30 + (1 << (29 - AMPLITUDE_BITS)))
                              >> (30 - AMPLITUDE_BITS);
    localparam logic signed [XW-1:0] X_INIT  = XW'(X_INIT_I);
    localparam logic signed [XW-1:0] LIM_POS = XW'(longint'(1) << AMPLITUDE_BITS);
    localparam logic signed [XW-1:0] LIM_NEG = -LIM_POS;
    localparam logic signed [PW-1:0] RND_HALF = PW'(longint'(1) << (AMPLITUDE_BITS - 1));
    localparam logic [ITER_W-1:0]    ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

    // configuration
    logic [15:0]        radius_reg;
    logic [31:0]        phase_step_reg;
    logic [31:0]        phase_offset_reg;
    logic signed [31:0] z_start_reg;
    logic signed [31:0] z_step_reg;
    logic [15:0]        last_index_reg;

    // path state
    logic [15:0]            index_count_reg, index_count_next;
    logic [PHASE_BITS-1:0]  phase_acc_reg, phase_acc_next;
    logic signed [31:0]     z_acc_reg, z_acc_next;
    logic                   finished_reg, finished_next;

    // sequencer
    hpg_state_t        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    // CORDIC and scaling datapath
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [31:0]   ang_reg, ang_next;
    logic [1:0]           quad_reg, quad_next;
    logic signed [XW-1:0] cos_reg, cos_next;
    logic signed [XW-1:0] sin_reg, sin_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [16:0]   px_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        sample_index_reg;
    logic signed [16:0] pos_x_reg;
    logic signed [16:0] pos_y_reg;
    logic signed [31:0] pos_z_reg;
    logic               is_last_reg;

    logic               in_xfer;
    logic               tick_emits;
    logic               out_load;
    logic signed [32:0] z_sum;
    logic [31:0]        phase_turn;
    logic [31:0]        quad_round;
    logic signed [XW-1:0] x_shift, y_shift;
    logic signed [31:0]   step_ang;
    logic signed [XW-1:0] c_raw, s_raw;
    logic signed [XW-1:0] mul_b;
    logic signed [PW-1:0] mul_res;
    logic signed [PW-1:0] prod_rnd;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign tick_emits = restart || !finished_reg;
    assign out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // -------------------------------------------------------------------
    // Configuration registers
    // -------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg       <= '0;
            phase_step_reg   <= '0;
            phase_offset_reg <= '0;
            z_start_reg      <= '0;
            z_step_reg       <= '0;
            last_index_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RADIUS:       radius_reg       <= cfg_data[15:0];
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                REG_PHASE_OFFSET: phase_offset_reg <= cfg_data;
                REG_Z_START:      z_start_reg      <= cfg_data;
                REG_Z_STEP:       z_step_reg       <= cfg_data;
                REG_LAST_INDEX:   last_index_reg   <= cfg_data[15:0];
                default:          ; // unmapped index: drop the write
            endcase
        end
    end

    // -------------------------------------------------------------------
    // Path accumulators: update on each tick that produces a sample
    // -------------------------------------------------------------------
    assign z_sum = 33'(z_acc_reg) + 33'(z_step_reg);

    always_comb
    begin
        index_count_next = index_count_reg;
        phase_acc_next   = phase_acc_reg;
        z_acc_next       = z_acc_reg;
        finished_next    = finished_reg;
        if (in_xfer && tick_emits)
        begin
            if (restart)
            begin
                index_count_next = '0;
                phase_acc_next   = PHASE_BITS'(phase_offset_reg);
                z_acc_next       = z_start_reg;
            end
            else
            begin
                index_count_next = index_count_reg + 16'd1;
                phase_acc_next   = phase_acc_reg + PHASE_BITS'(phase_step_reg);
                // saturate on signed overflow
                if (z_sum[32] != z_sum[31])
                    z_acc_next = z_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                else
                    z_acc_next = z_sum[31:0];
            end
            finished_next = (index_count_next == last_index_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_count_reg <= '0;
            phase_acc_reg   <= '0;
            z_acc_reg       <= '0;
            finished_reg    <= 1'b1;
        end
        else
        begin
            index_count_reg <= index_count_next;
            phase_acc_reg   <= phase_acc_next;
            z_acc_reg       <= z_acc_next;
            finished_reg    <= finished_next;
        end
    end

    // -------------------------------------------------------------------
    // Shared datapath: quadrant split, CORDIC step, quadrant fold, multiply
    // -------------------------------------------------------------------
    // bring the phase to 32 bits per turn
    assign phase_turn = 32'(phase_acc_reg >> PH_DOWN) << PH_UP;
    assign quad_round = phase_turn + 32'h2000_0000;

    assign x_shift  = x_reg >>> iter_reg;
    assign y_shift  = y_reg >>> iter_reg;
    assign step_ang = atan_angle(iter_reg);

    always_comb
    begin
        case (quad_reg)
            2'd0:    begin c_raw = x_reg;  s_raw = y_reg;  end
            2'd1:    begin c_raw = -y_reg; s_raw = x_reg;  end
            2'd2:    begin c_raw = -x_reg; s_raw = -y_reg; end
            default: begin c_raw = y_reg;  s_raw = -x_reg; end
        endcase
    end

    assign mul_b    = (state_reg == ST_MULX) ? cos_reg : sin_reg;
    assign mul_res  = PW'($signed({1'b0, radius_reg})) * PW'(mul_b);
    assign prod_rnd = prod_reg + RND_HALF;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ang_next       = ang_reg;
        quad_next      = quad_reg;
        cos_next       = cos_reg;
        sin_next       = sin_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && tick_emits)
                    state_next = ST_INIT;
            end
            ST_INIT:
            begin
                // split off the quadrant, keep the signed residual angle
                quad_next  = quad_round[31:30];
                ang_next   = phase_turn - {quad_round[31:30], 30'd0};
                x_next     = X_INIT;
                y_next     = '0;
                iter_next  = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                if (!ang_reg[31])
                begin
                    x_next   = x_reg - y_shift;
                    y_next   = y_reg + x_shift;
                    ang_next = ang_reg - step_ang;
                end
                else
                begin
                    x_next   = x_reg + y_shift;
                    y_next   = y_reg - x_shift;
                    ang_next = ang_reg + step_ang;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST)
                    state_next = ST_QUAD;
            end
            ST_QUAD:
            begin
                // rotate back by whole quarter turns and clamp to unit amplitude
                cos_next = (c_raw > LIM_POS) ? LIM_POS :
                           ((c_raw < LIM_NEG) ? LIM_NEG : c_raw);
                sin_next = (s_raw > LIM_POS) ? LIM_POS :
                           ((s_raw < LIM_NEG) ? LIM_NEG : s_raw);
                state_next = ST_MULX;
            end
            ST_MULX:
            begin
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold here until the output register is free
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        ang_reg  <= ang_next;
        quad_reg <= quad_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
        if (state_reg == ST_MULX || state_reg == ST_MULY)
            prod_reg <= mul_res;
        // x product is ready while y is multiplied: round it here
        if (state_reg == ST_MULY)
            px_reg <= prod_rnd[AMPLITUDE_BITS +: 17];
        if (out_load)
        begin
            sample_index_reg <= index_count_reg;
            pos_x_reg        <= px_reg;
            pos_y_reg        <= prod_rnd[AMPLITUDE_BITS +: 17];
            pos_z_reg        <= z_acc_reg;
            is_last_reg      <= (index_count_reg == last_index_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_index = sample_index_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;
    assign is_last      = is_last_reg;

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
`include "helix_position_generator_assert.svh"

    `HPG_ASSERT_NEXT(a_rot_ends, (state_reg == ST_ROT) && (iter_reg == ITER_LAST), (state_reg == ST_QUAD), "CORDIC did not finish after the last step")
    `HPG_ASSERT_NEXT(a_emit_waits, (state_reg == ST_EMIT) && out_valid_reg && !out_ready, (state_reg == ST_EMIT) && out_valid_reg, "sample loaded over a stalled result")
    `HPG_ASSERT_NEXT(a_idle_tick, in_valid && in_ready && !restart && finished_reg, (state_reg == ST_IDLE), "tick after the last sample started a computation")

endmodule
